// ===== hw/rtl/wlfo_pkg.sv =====
// Shared types and constants of the wavetable LFO.
`timescale 1ns / 1ps

package wlfo_pkg;

  // Fixed field widths of the stream items and the configuration registers.
  localparam int OpW        = 2;
  localparam int SelW       = 3;
  localparam int TabAddrW   = 8;
  localparam int WordW      = 16;
  localparam int StepW      = 16;
  localparam int WaveW      = 3;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam int InTdataW   = 32;
  localparam int OutTdataW  = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegStepRate = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWaveform = 2'd1;

  // Operation codes carried in the op field of an input item.
  typedef enum logic [OpW-1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef logic signed [WordW-1:0] sample_t;

endpackage

// ===== hw/rtl/wavetable_lfo_interpolated_unit.sv =====
// Top level of the wavetable LFO with linear interpolation.
`timescale 1ns / 1ps

// Wavetable LFO. The phase accumulator has log2(TABLE_ENTRIES) + FRAC_BITS bits; its upper
// bits pick an entry of the selected waveform table and its lower FRAC_BITS bits interpolate
// toward the next entry, wrapping from the last entry to entry 0. A tick (op 0) emits the
// sample of the current phase and then advances the phase by twice step_rate; a table write
// (op 1) stores one word; a restart (op 2) clears the phase. All tables share one single-port
// memory of NUM_WAVES * TABLE_ENTRIES words with a registered read, and that port sets the
// rate: a tick reads it twice (once per neighboring entry) and holds off the input during its
// second read; a write or restart uses it once, so other items can be taken every cycle while
// no second read is under way. A sample is interpolated from both reads and waits in a
// two-entry output queue; at most two ticks are outstanding, so besides a tick's second read
// the input stalls only when the output is held off. TABLE_ENTRIES must be a power of two.
// Table entries must be written before a tick reads them; the store is not cleared by reset.
module wavetable_lfo_interpolated_unit #(
  parameter int TABLE_ENTRIES = 256,
  parameter int NUM_WAVES     = 5,
  parameter int FRAC_BITS     = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input items.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [1:0] op, [4:2] table_select, [12:5] table_addr, [28:13] table_word, [31:29] zero.
  input  logic [wlfo_pkg::InTdataW-1:0]       s_axis_tdata,
  // Result items.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] sample.
  output logic [wlfo_pkg::OutTdataW-1:0]      m_axis_tdata,
  // Configuration writes.
  input  logic                                cfg_we_i,
  input  logic [wlfo_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [wlfo_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int IdxW   = $clog2(TABLE_ENTRIES);
  localparam int PhaseW = IdxW + FRAC_BITS;
  localparam int Depth  = NUM_WAVES * TABLE_ENTRIES;
  localparam int AddrW  = $clog2(Depth);
  localparam int DiffW  = wlfo_pkg::WordW + 1;
  localparam int ProdW  = FRAC_BITS + 1 + DiffW;

  // Input field unpacking.
  wlfo_pkg::op_e                     in_op;
  logic [wlfo_pkg::SelW-1:0]         in_sel;
  logic [wlfo_pkg::TabAddrW-1:0]     in_addr;
  wlfo_pkg::sample_t                 in_word;

  assign in_op   = wlfo_pkg::op_e'(s_axis_tdata[1:0]);
  assign in_sel  = s_axis_tdata[4:2];
  assign in_addr = s_axis_tdata[12:5];
  assign in_word = s_axis_tdata[28:13];

  // Configuration registers.
  logic [wlfo_pkg::StepW-1:0] step_rate_q, step_rate_d;
  logic [wlfo_pkg::WaveW-1:0] waveform_q, waveform_d;

  always_comb begin
    step_rate_d = step_rate_q;
    waveform_d  = waveform_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wlfo_pkg::RegStepRate: step_rate_d = cfg_data_i[wlfo_pkg::StepW-1:0];
        wlfo_pkg::RegWaveform: begin
          if (int'(cfg_data_i[wlfo_pkg::WaveW-1:0]) < NUM_WAVES) begin
            waveform_d = cfg_data_i[wlfo_pkg::WaveW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Control state.
  logic              busy_q;
  logic              s2_q;
  logic [1:0]        tick_cnt_q, tick_cnt_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [1:0]        fcnt_q, fcnt_d;
  logic              wr_ptr_q, rd_ptr_q;

  // Datapath registers.
  logic [AddrW-1:0]     x1_addr_q;
  logic [FRAC_BITS-1:0] frac_q;
  wlfo_pkg::sample_t    y0_q;
  wlfo_pkg::sample_t    fifo_q [2];

  logic in_xfer, out_xfer;
  logic tick_go, wr_go, restart_go;

  assign s_axis_tready = !busy_q && (tick_cnt_q < 2'd2);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  always_comb begin
    tick_go    = 1'b0;
    wr_go      = 1'b0;
    restart_go = 1'b0;
    if (in_xfer) begin
      unique case (in_op)
        wlfo_pkg::OP_TICK:    tick_go = 1'b1;
        wlfo_pkg::OP_WRITE:   wr_go = (int'(in_sel) < NUM_WAVES) &&
                                      (int'(in_addr) < TABLE_ENTRIES);
        wlfo_pkg::OP_RESTART: restart_go = 1'b1;
        default: ;
      endcase
    end
  end

  // Phase split and table addresses.
  logic [IdxW-1:0]      x0, x1;
  logic [AddrW-1:0]     rd0_addr, x1_addr, wr_addr;

  assign x0       = phase_q[PhaseW-1 -: IdxW];
  assign x1       = x0 + 1'b1;
  assign rd0_addr = (AddrW'(waveform_q) << IdxW) | AddrW'(x0);
  assign x1_addr  = (AddrW'(waveform_q) << IdxW) | AddrW'(x1);
  assign wr_addr  = (AddrW'(in_sel) << IdxW) | AddrW'(in_addr);

  always_comb begin
    phase_d = phase_q;
    if (restart_go) begin
      phase_d = '0;
    end else if (tick_go) begin
      phase_d = phase_q + PhaseW'({step_rate_q, 1'b0});
    end
  end

  // Memory port: the second read of a tick owns the port, otherwise the new item uses it.
  logic              mem_we;
  logic [AddrW-1:0]  mem_addr;
  wlfo_pkg::sample_t mem_rdata;

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = x1_addr_q;
    if (!busy_q) begin
      if (wr_go) begin
        mem_we   = 1'b1;
        mem_addr = wr_addr;
      end else begin
        mem_addr = rd0_addr;
      end
    end
  end

  wlfo_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (in_word),
    .rdata_o (mem_rdata)
  );

  // Interpolation: y0 + floor(frac * (y1 - y0) / 2^FRAC_BITS), with y1 on the read port.
  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] prod_sh;
  wlfo_pkg::sample_t       sample;

  assign diff    = $signed({mem_rdata[wlfo_pkg::WordW-1], mem_rdata}) -
                   $signed({y0_q[wlfo_pkg::WordW-1], y0_q});
  assign prod    = $signed({1'b0, frac_q}) * diff;
  assign prod_sh = prod >>> FRAC_BITS;
  assign sample  = y0_q + prod_sh[wlfo_pkg::WordW-1:0];

  // Outstanding ticks and output queue occupancy.
  always_comb begin
    tick_cnt_d = tick_cnt_q;
    if (tick_go && !out_xfer) begin
      tick_cnt_d = tick_cnt_q + 2'd1;
    end else if (!tick_go && out_xfer) begin
      tick_cnt_d = tick_cnt_q - 2'd1;
    end
  end

  always_comb begin
    fcnt_d = fcnt_q;
    if (s2_q && !out_xfer) begin
      fcnt_d = fcnt_q + 2'd1;
    end else if (!s2_q && out_xfer) begin
      fcnt_d = fcnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_rate_q <= '0;
      waveform_q  <= '0;
      phase_q     <= '0;
      busy_q      <= 1'b0;
      s2_q        <= 1'b0;
      tick_cnt_q  <= '0;
      fcnt_q      <= '0;
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
    end else begin
      step_rate_q <= step_rate_d;
      waveform_q  <= waveform_d;
      phase_q     <= phase_d;
      busy_q      <= tick_go;
      s2_q        <= busy_q;
      tick_cnt_q  <= tick_cnt_d;
      fcnt_q      <= fcnt_d;
      if (s2_q) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (out_xfer) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      x1_addr_q <= x1_addr;
      frac_q    <= phase_q[FRAC_BITS-1:0];
    end
    if (busy_q) begin
      y0_q <= mem_rdata;
    end
    if (s2_q) begin
      fifo_q[wr_ptr_q] <= sample;
    end
  end

  assign m_axis_tvalid = (fcnt_q != 2'd0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q];

  // The credit limit must keep outstanding ticks within the output queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_cnt_q <= 2'd2) && (fcnt_q <= tick_cnt_q))
    else $error("outstanding tick count out of range");

  // A finished sample must always find room in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_q |-> ((fcnt_q < 2'd2) || out_xfer))
    else $error("output queue overflow");

  // An accepted tick takes the port for its second read in the next cycle only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_go |=> (busy_q && !s_axis_tready) ##1 (s2_q && !busy_q))
    else $error("tick read sequence broken");

endmodule

// ===== hw/rtl/wlfo_ram.sv =====
// Single-port waveform store with a registered read.
`timescale 1ns / 1ps

module wlfo_ram #(
  parameter int Depth = 1280,
  parameter int AddrW = 11
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        addr_i,
  input  wlfo_pkg::sample_t       wdata_i,
  output wlfo_pkg::sample_t       rdata_o
);

  wlfo_pkg::sample_t mem_q [Depth];
  wlfo_pkg::sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
